// ----- src/tlav_pkg.sv -----
// ----------------------------------------------------------------------------
// tlav_pkg
// Shared types and constants of the target line arrow vertex generator.
// ----------------------------------------------------------------------------
package tlav_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_WIDTH     = 32;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int MAG_WIDTH       = 31;
    localparam int ROOT_WIDTH      = 32;
    localparam int RAD_WIDTH       = 2 * ROOT_WIDTH;
    localparam int PROD_WIDTH      = 2 * MAG_WIDTH;
    localparam int QUOT_WIDTH      = 31;
    localparam int SUM_WIDTH       = COORD_WIDTH + 2;
    localparam int INDEX_WIDTH     = 32;
    localparam int COLOUR_WIDTH    = 32;

    // iteration counts
    localparam int ROOT_STEPS      = ROOT_WIDTH;
    localparam int DIV_STEPS       = QUOT_WIDTH;
    localparam int CNT_WIDTH       = 5;

    // length over ten: half the length times ceil(2^34 / 5), shifted down by 34
    localparam logic [ROOT_WIDTH-1:0] RECIP_FIFTH = 32'hCCCC_CCCD;
    localparam int                    RECIP_SHIFT = 34;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ARROW   = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LINE_COLOUR = 1'd1;
    localparam logic [QUOT_WIDTH-1:0]      MAX_ARROW_RESET = 31'd4096;
    localparam logic [COLOUR_WIDTH-1:0]    COLOUR_RESET    = 32'hFFFF_FFFF;

    // quotient targets: three direction steps, two perpendicular steps
    localparam logic [2:0] TGT_TX = 3'd0;
    localparam logic [2:0] TGT_TY = 3'd1;
    localparam logic [2:0] TGT_TZ = 3'd2;
    localparam logic [2:0] TGT_BX = 3'd3;
    localparam logic [2:0] TGT_BY = 3'd4;

    // vertex slots of one line
    localparam logic [2:0] VTX_START = 3'd0;
    localparam logic [2:0] VTX_END   = 3'd1;
    localparam logic [2:0] VTX_MID_A = 3'd2;
    localparam logic [2:0] VTX_BARB1 = 3'd3;
    localparam logic [2:0] VTX_MID_B = 3'd4;
    localparam logic [2:0] VTX_BARB2 = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_z;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]        vertex_index;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [COLOUR_WIDTH-1:0]       colour;
        logic                          last;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       prep;
        logic       mul_en;
        logic       mul_sq;
        logic [2:0] tgt;
        logic       acc_clr;
        logic       acc_en;
        logic       root_step;
        logic       store_len;
        logic       store_plen;
        logic       div_load;
        logic       div_step;
        logic       store_arrow;
        logic       store_q;
        logic       emit;
        logic [2:0] vtx;
    } tlav_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } tlav_sts_t;

endpackage

// ----- src/tlav_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlav_ctrl
// Sequencer: squares, two roots, five quotients, then six vertices.
// ----------------------------------------------------------------------------
module tlav_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                line_valid,
    output logic                line_stall,
    input  tlav_pkg::tlav_sts_t sts,
    output tlav_pkg::tlav_cmd_t cmd
);
    import tlav_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_SQ3  = 4'd2;
    localparam logic [3:0] S_RT3  = 4'd3;
    localparam logic [3:0] S_LEN  = 4'd4;
    localparam logic [3:0] S_SQ2  = 4'd5;
    localparam logic [3:0] S_RT2  = 4'd6;
    localparam logic [3:0] S_PLEN = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DST  = 4'd9;
    localparam logic [3:0] S_MUL  = 4'd10;
    localparam logic [3:0] S_DLD  = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [2:0]           tgt_reg, tgt_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            tgt_reg   <= TGT_TX;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign line_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tgt_next   = tgt_reg;
        cmd        = '0;
        cmd.tgt    = tgt_reg;
        cmd.vtx    = cnt_reg[2:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (line_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep    = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = '0;
                state_next  = S_SQ3;
            end
            S_SQ3:
            begin
                cmd.mul_en = (cnt_reg < CNT_WIDTH'(3));
                cmd.mul_sq = 1'b1;
                cmd.tgt    = cnt_reg[2:0];
                cmd.acc_en = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_RT3;
                end
            end
            S_RT3:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.store_len = 1'b1;
                cmd.acc_clr   = 1'b1;
                state_next    = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.mul_en = (cnt_reg < CNT_WIDTH'(2));
                cmd.mul_sq = 1'b1;
                cmd.tgt    = TGT_BX + cnt_reg[2:0];
                cmd.acc_en = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(2))
                begin
                    cnt_next   = '0;
                    state_next = S_RT2;
                end
            end
            S_RT2:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_PLEN;
                end
            end
            S_PLEN:
            begin
                cmd.store_plen  = 1'b1;
                cmd.store_arrow = 1'b1;
                tgt_next        = TGT_TX;
                state_next      = S_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DST;
                end
            end
            S_DST:
            begin
                cmd.store_q = 1'b1;
                if (tgt_reg != TGT_BY)
                begin
                    tgt_next   = tgt_reg + 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_DLD;
            end
            S_DLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[2:0] == VTX_BARB2)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tlav_dp.sv -----
// ----------------------------------------------------------------------------
// tlav_dp
// Datapath: operand registers, shared multiplier, root and divider units,
// configuration registers and the vertex output register.
// ----------------------------------------------------------------------------
module tlav_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  tlav_pkg::in_item_t                       line_data,
    input  logic                                     cfg_we,
    input  logic [tlav_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [tlav_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  tlav_pkg::tlav_cmd_t                      cmd,
    output tlav_pkg::tlav_sts_t                      sts,
    output logic                                     vtx_valid,
    input  logic                                     vtx_stall,
    output tlav_pkg::out_item_t                      vtx_data
);
    import tlav_pkg::*;

    logic [QUOT_WIDTH-1:0]          max_arrow_reg;
    logic [COLOUR_WIDTH-1:0]        colour_reg;
    logic [INDEX_WIDTH-1:0]         count_reg;

    logic signed [COORD_WIDTH-1:0]  s_reg   [3];
    logic signed [COORD_WIDTH-1:0]  e_reg   [3];
    logic signed [COORD_WIDTH-1:0]  mid_reg [3];
    logic signed [DIFF_WIDTH-1:0]   d_reg   [3];
    logic [MAG_WIDTH-1:0]           a3_reg  [3];
    logic [MAG_WIDTH-1:0]           a2_reg  [2];
    logic [1:0]                     k3_reg;
    logic [ROOT_WIDTH-1:0]          len_reg;
    logic [ROOT_WIDTH-1:0]          plen_reg;
    logic [QUOT_WIDTH-1:0]          arrow_reg;
    logic [QUOT_WIDTH-1:0]          q_store_reg [5];

    logic [PROD_WIDTH-1:0]          prod_reg;
    logic [RAD_WIDTH-1:0]           sum_reg;
    logic [ROOT_WIDTH+2:0]          rrem_reg;
    logic [ROOT_WIDTH-1:0]          root_reg;
    logic [ROOT_WIDTH-1:0]          drem_reg;
    logic [ROOT_WIDTH-1:0]          den_reg;
    logic [QUOT_WIDTH-1:0]          lo_reg;
    logic [QUOT_WIDTH-1:0]          quot_reg;

    logic                           out_valid_reg;
    out_item_t                      out_reg;

    // magnitude of a difference
    function automatic logic [DIFF_WIDTH-1:0] mag_of(input logic signed [DIFF_WIDTH-1:0] v);
        mag_of = v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
    endfunction

    // quotient with the sign of a difference
    function automatic logic signed [SUM_WIDTH-1:0] signed_q(input logic neg,
                                                             input logic [QUOT_WIDTH-1:0] q);
        logic signed [SUM_WIDTH-1:0] pos;
        pos = $signed(SUM_WIDTH'(q));
        signed_q = neg ? -pos : pos;
    endfunction

    // clamp to the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = $signed(SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
        lo = -hi - SUM_WIDTH'(1);
        if (v > hi)
            sat = hi[COORD_WIDTH-1:0];
        else if (v < lo)
            sat = lo[COORD_WIDTH-1:0];
        else
            sat = v[COORD_WIDTH-1:0];
    endfunction

    // input coordinates as arrays
    logic signed [COORD_WIDTH-1:0] in_s [3];
    logic signed [COORD_WIDTH-1:0] in_e [3];
    assign in_s[0] = line_data.start_x;
    assign in_s[1] = line_data.start_y;
    assign in_s[2] = line_data.start_z;
    assign in_e[0] = line_data.end_x;
    assign in_e[1] = line_data.end_y;
    assign in_e[2] = line_data.end_z;

    // magnitudes and the pre-shift of both lengths
    logic [DIFF_WIDTH-1:0] m [3];
    logic [1:0]            k3;
    logic [1:0]            k2;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m[i] = mag_of(d_reg[i]);
        if (m[0][DIFF_WIDTH-1] | m[1][DIFF_WIDTH-1] | m[2][DIFF_WIDTH-1])
            k3 = 2'd2;
        else if (m[0][DIFF_WIDTH-2] | m[1][DIFF_WIDTH-2] | m[2][DIFF_WIDTH-2])
            k3 = 2'd1;
        else
            k3 = 2'd0;
        if (m[0][DIFF_WIDTH-1] | m[1][DIFF_WIDTH-1])
            k2 = 2'd2;
        else if (m[0][DIFF_WIDTH-2] | m[1][DIFF_WIDTH-2])
            k2 = 2'd1;
        else
            k2 = 2'd0;
    end

    // multiplier operand select
    logic [MAG_WIDTH-1:0] mul_a;
    logic [MAG_WIDTH-1:0] mul_b;
    always_comb
    begin
        case (cmd.tgt)
            TGT_TX:  mul_a = a3_reg[0];
            TGT_TY:  mul_a = a3_reg[1];
            TGT_TZ:  mul_a = a3_reg[2];
            TGT_BX:  mul_a = a2_reg[1];
            default: mul_a = a2_reg[0];
        endcase
        mul_b = cmd.mul_sq ? mul_a : arrow_reg;
    end

    // root step: two radicand bits per cycle
    logic [ROOT_WIDTH+4:0] rt_rem2;
    logic [ROOT_WIDTH+4:0] rt_trial;
    logic                  rt_ge;
    logic [ROOT_WIDTH+4:0] rt_diff;
    assign rt_rem2  = {rrem_reg, sum_reg[RAD_WIDTH-1 -: 2]};
    assign rt_trial = {3'b000, root_reg, 2'b01};
    assign rt_ge    = (rt_rem2 >= rt_trial);
    assign rt_diff  = rt_rem2 - rt_trial;

    // divide step: one quotient bit per cycle
    logic [ROOT_WIDTH:0] dv_rem2;
    logic                dv_ge;
    logic [ROOT_WIDTH:0] dv_diff;
    assign dv_rem2 = {drem_reg, lo_reg[QUOT_WIDTH-1]};
    assign dv_ge   = (dv_rem2 >= {1'b0, den_reg});
    assign dv_diff = dv_rem2 - {1'b0, den_reg};

    // divider denominator
    logic [ROOT_WIDTH-1:0] dv_den;
    logic                  den_zero;
    assign dv_den   = (cmd.tgt < TGT_BX) ? len_reg : plen_reg;
    assign den_zero = (dv_den == '0);

    // length over ten: half of the unshifted length divided by five
    logic [ROOT_WIDTH-1:0] len_half;
    logic [RAD_WIDTH-1:0]  ten_prod;
    logic [QUOT_WIDTH-1:0] len_tenth;
    assign len_half  = (k3_reg != 2'd0) ? len_reg : (len_reg >> 1);
    assign ten_prod  = RAD_WIDTH'(len_half) * RAD_WIDTH'(RECIP_FIFTH);
    assign len_tenth = QUOT_WIDTH'(ten_prod[RAD_WIDTH-1:RECIP_SHIFT]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_arrow_reg <= MAX_ARROW_RESET;
            colour_reg    <= COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ARROW:   max_arrow_reg <= cfg_data[QUOT_WIDTH-1:0];
                CFG_LINE_COLOUR: colour_reg    <= cfg_data[COLOUR_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // operand registers and iterative units
    always_ff @(posedge clk)
    begin
        logic signed [COORD_WIDTH:0] sum_se;
        if (cmd.load_in)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_se     = DIFF_WIDTH'(in_s[i]) + DIFF_WIDTH'(in_e[i]);
                s_reg[i]   <= in_s[i];
                e_reg[i]   <= in_e[i];
                mid_reg[i] <= sum_se[COORD_WIDTH:1];
                d_reg[i]   <= DIFF_WIDTH'(in_e[i]) - DIFF_WIDTH'(in_s[i]);
            end
        end
        if (cmd.prep)
        begin
            for (int i = 0; i < 3; i++)
                a3_reg[i] <= MAG_WIDTH'(m[i] >> k3);
            for (int i = 0; i < 2; i++)
                a2_reg[i] <= MAG_WIDTH'(m[i] >> k2);
            k3_reg <= k3;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.acc_clr)
        begin
            sum_reg  <= '0;
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.acc_en)
            sum_reg <= sum_reg + RAD_WIDTH'(prod_reg);
        else if (cmd.root_step)
        begin
            sum_reg  <= sum_reg << 2;
            rrem_reg <= rt_ge ? rt_diff[ROOT_WIDTH+2:0] : rt_rem2[ROOT_WIDTH+2:0];
            root_reg <= {root_reg[ROOT_WIDTH-2:0], rt_ge};
        end
        if (cmd.store_len)
            len_reg <= root_reg;
        if (cmd.store_plen)
            plen_reg <= root_reg;
        if (cmd.div_load)
        begin
            drem_reg <= ROOT_WIDTH'(prod_reg[PROD_WIDTH-1:QUOT_WIDTH]);
            lo_reg   <= prod_reg[QUOT_WIDTH-1:0];
            den_reg  <= dv_den;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            drem_reg <= dv_ge ? dv_diff[ROOT_WIDTH-1:0] : dv_rem2[ROOT_WIDTH-1:0];
            lo_reg   <= lo_reg << 1;
            quot_reg <= {quot_reg[QUOT_WIDTH-2:0], dv_ge};
        end
        if (cmd.store_arrow)
            arrow_reg <= (len_tenth > max_arrow_reg) ? max_arrow_reg : len_tenth;
        if (cmd.store_q)
            q_store_reg[cmd.tgt] <= den_zero ? '0 : quot_reg;
    end

    // signed direction and perpendicular steps
    logic signed [SUM_WIDTH-1:0] t  [3];
    logic signed [SUM_WIDTH-1:0] b  [3];
    logic signed [SUM_WIDTH-1:0] bs [3];
    logic signed [SUM_WIDTH-1:0] mw [3];
    logic signed [COORD_WIDTH-1:0] pos [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t[i] = signed_q(d_reg[i][DIFF_WIDTH-1], q_store_reg[i]);
        b[0] = signed_q(d_reg[1][DIFF_WIDTH-1], q_store_reg[3]);
        b[1] = signed_q(!d_reg[0][DIFF_WIDTH-1], q_store_reg[4]);
        b[2] = '0;
        for (int i = 0; i < 3; i++)
        begin
            mw[i] = SUM_WIDTH'(mid_reg[i]);
            bs[i] = mw[i] - t[i];
            case (cmd.vtx)
                VTX_START: pos[i] = s_reg[i];
                VTX_END:   pos[i] = e_reg[i];
                VTX_BARB1: pos[i] = sat(bs[i] + b[i]);
                VTX_BARB2: pos[i] = sat(bs[i] - b[i]);
                default:   pos[i] = mid_reg[i];
            endcase
        end
    end

    // vertex output register and running index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
            count_reg     <= count_reg + 1'b1;
        end
        else if (!vtx_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.vertex_index <= count_reg;
            out_reg.pos_x        <= pos[0];
            out_reg.pos_y        <= pos[1];
            out_reg.pos_z        <= pos[2];
            out_reg.colour       <= colour_reg;
            out_reg.last         <= (cmd.vtx == VTX_BARB2);
        end
    end

    assign sts.out_free = !out_valid_reg || !vtx_stall;
    assign vtx_valid    = out_valid_reg;
    assign vtx_data     = out_reg;

endmodule

// ----- src/target_line_arrow_vertex_gen.sv -----
// Once a line is accepted, its vertices follow its arithmetic at one vertex
// per cycle while the sink takes them; a new line is taken after the sixth
// vertex is loaded. The time per line is set by the one-bit-per-cycle
// divider, used for five quotients, and the two-bit-per-cycle root unit,
// used for both lengths.
// Reset clears the sequencer, the vertex index and loads register defaults.
// ----------------------------------------------------------------------------
// target_line_arrow_vertex_gen
// Top level: arrow vertices for a target line from its start and end points.
// ----------------------------------------------------------------------------
module target_line_arrow_vertex_gen (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 line_valid,
    output logic                                 line_stall,
    input  tlav_pkg::in_item_t                   line_data,
    output logic                                 vtx_valid,
    input  logic                                 vtx_stall,
    output tlav_pkg::out_item_t                  vtx_data,
    input  logic                                 cfg_we,
    input  logic [tlav_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tlav_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import tlav_pkg::*;

    tlav_cmd_t cmd;
    tlav_sts_t sts;

    // sequencer
    tlav_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // arithmetic and output register
    tlav_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_data (line_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx_data  (vtx_data)
    );

endmodule

// ----- src/tlav_checker.sv -----
// ----------------------------------------------------------------------------
// tlav_checker
// Port-level checks of the arrow vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module tlav_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 line_valid,
    input logic                                 line_stall,
    input logic                                 vtx_valid,
    input logic                                 vtx_stall,
    input tlav_pkg::out_item_t                  vtx_data
);
    import tlav_pkg::*;

    // a stalled vertex holds
    a_vtx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_stall |=> vtx_valid && $stable(vtx_data))
        else $error("stalled vertex changed");

    // one line at a time
    a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_stall |=> line_stall)
        else $error("second line taken while busy");

    // no new line while a line's vertices are still pending
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && !vtx_data.last |-> line_stall)
        else $error("line input open mid-emission");

    // the vertex after a taken non-last vertex carries the next index
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && !vtx_stall && !vtx_data.last ##1 vtx_valid
        |-> vtx_data.vertex_index == $past(vtx_data.vertex_index) + 32'd1)
        else $error("vertex index skipped");

endmodule

bind target_line_arrow_vertex_gen tlav_checker u_tlav_checker (.*);
